FILE: design/qti_pkg.sv
package qti_pkg;

  // grid size per axis
  localparam int ANGLE_POINTS    = 16;
  localparam int DISTANCE_POINTS = 16;
  localparam int RC_POINTS       = 8;
  localparam int DRIFT_POINTS    = 8;

  localparam int TABLE_DEPTH = ANGLE_POINTS * DISTANCE_POINTS * RC_POINTS * DRIFT_POINTS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // index registers hold up to 256 points
  localparam int IDX_W = 8;

  localparam int COORD_W = 24;
  localparam int STEP_W  = 24;
  localparam int VALUE_W = 16;
  localparam int POS_W   = COORD_W + STEP_W;
  localparam int FRAC_W  = 14;
  localparam int WGT_W   = FRAC_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_ANGLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_DISTANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_RC       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_DRIFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RC_OFFSET         = 3'd4;

  localparam logic [STEP_W-1:0]     INV_STEP_RESET  = 24'd65536;
  localparam logic [CFG_DATA_W-1:0] RC_OFFSET_RESET = 24'd12800;

  localparam logic [1:0] AXIS_ANGLE    = 2'd0;
  localparam logic [1:0] AXIS_DISTANCE = 2'd1;
  localparam logic [1:0] AXIS_RC       = 2'd2;
  localparam logic [1:0] AXIS_DRIFT    = 2'd3;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  function automatic logic [IDX_W-1:0] axis_last(input logic [1:0] axis);
    logic [IDX_W-1:0] last;
    unique case (axis)
      AXIS_ANGLE:    last = IDX_W'(ANGLE_POINTS - 1);
      AXIS_DISTANCE: last = IDX_W'(DISTANCE_POINTS - 1);
      AXIS_RC:       last = IDX_W'(RC_POINTS - 1);
      default:       last = IDX_W'(DRIFT_POINTS - 1);
    endcase
    return last;
  endfunction

endpackage

FILE: design/qti_item_if.sv
interface qti_item_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [qti_pkg::COORD_W-1:0]     angle_coord;
  logic [qti_pkg::COORD_W-1:0]     distance_coord;
  logic [qti_pkg::COORD_W-1:0]     rc_coord;
  logic [qti_pkg::COORD_W-1:0]     drift_coord;
  logic [qti_pkg::VALUE_W-1:0]     entry_value;

  modport source (
    output valid, req_type, angle_coord, distance_coord, rc_coord, drift_coord, entry_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, angle_coord, distance_coord, rc_coord, drift_coord, entry_value,
    output ready
  );
endinterface

FILE: design/qti_result_if.sv
interface qti_result_if;
  logic                        valid;
  logic                        ready;
  logic [qti_pkg::VALUE_W-1:0] ratio;
  logic                        clamped;

  modport source (
    output valid, ratio, clamped,
    input  ready
  );
  modport sink (
    input  valid, ratio, clamped,
    output ready
  );
endinterface

FILE: design/quadrilinear_table_interpolator_top.sv
// Four-dimensional weight table (angle, impact distance, RC, drift) held in one
// single-port-write, registered-read memory. After reset a clearing pass zeroes all
// TABLE_DEPTH entries (16384 at the default grid), one a cycle; no word is accepted
// in that time, configuration writes are. Work is one word at a time: each of the
// four coordinates is scaled on one shared 24x24 multiplier, one axis a cycle. A
// query then reads its 16 corner entries through the single memory read port, one
// a cycle, into a four-deep weighting pipeline; the rounded and saturated sum goes
// to the output register. The next word is taken while a result waits there.
module quadrilinear_table_interpolator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [qti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qti_pkg::CFG_DATA_W-1:0]      cfg_data,
  qti_item_if.sink                            item,
  qti_result_if.source                        result
);

  localparam int AW    = qti_pkg::ADDR_W;
  localparam int IW    = qti_pkg::IDX_W;
  localparam int CW    = qti_pkg::COORD_W;
  localparam int SW    = qti_pkg::STEP_W;
  localparam int PW    = qti_pkg::POS_W;
  localparam int FW    = qti_pkg::FRAC_W;
  localparam int WW    = qti_pkg::WGT_W;
  localparam int VW    = qti_pkg::VALUE_W;
  localparam int PAIR_W = 2 * WW;
  localparam int CORNER_W = 29;
  localparam int PROD_W = VW + CORNER_W;
  localparam int ACC_W  = PROD_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_BLEND = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [WW-1:0] ONE_W = WW'(1 << FW);

  function automatic logic [AW-1:0] grid_addr(input logic [IW-1:0] a, input logic [IW-1:0] d,
                                              input logic [IW-1:0] r, input logic [IW-1:0] z);
    logic [AW-1:0] ad;
    logic [AW-1:0] adr;
    ad  = AW'(a) * AW'(qti_pkg::DISTANCE_POINTS) + AW'(d);
    adr = ad * AW'(qti_pkg::RC_POINTS) + AW'(r);
    return adr * AW'(qti_pkg::DRIFT_POINTS) + AW'(z);
  endfunction

  // configuration
  logic [SW-1:0] inv_angle;
  logic [SW-1:0] inv_distance;
  logic [SW-1:0] inv_rc;
  logic [SW-1:0] inv_drift;
  logic [CW-1:0] rc_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_angle    <= qti_pkg::INV_STEP_RESET;
      inv_distance <= qti_pkg::INV_STEP_RESET;
      inv_rc       <= qti_pkg::INV_STEP_RESET;
      inv_drift    <= qti_pkg::INV_STEP_RESET;
      rc_offset    <= qti_pkg::RC_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qti_pkg::REG_INV_STEP_ANGLE:    inv_angle    <= cfg_data;
        qti_pkg::REG_INV_STEP_DISTANCE: inv_distance <= cfg_data;
        qti_pkg::REG_INV_STEP_RC:       inv_rc       <= cfg_data;
        qti_pkg::REG_INV_STEP_DRIFT:    inv_drift    <= cfg_data;
        qti_pkg::REG_RC_OFFSET:         rc_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [2:0]    step;
  logic [4:0]    corner;
  logic          v1, v2, v3;
  logic          out_valid;

  // latched word
  logic          req;
  logic [CW-1:0] ca, cd, cz, rc_mag;
  logic          rc_below;
  logic [VW-1:0] value;

  // per-axis results
  logic [PW-1:0] pos;
  logic [IW-1:0] lo   [4];
  logic [IW-1:0] hi   [4];
  logic [FW-1:0] frac [4];
  logic [IW-1:0] ridx [4];
  logic          clamp;
  logic          load_ok;

  // blend pipeline
  logic [PAIR_W-1:0]   w01, w23;
  logic [CORNER_W-1:0] wc;
  logic [VW-1:0]       rdata, val;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    acc;

  logic [VW-1:0] ratio_q;
  logic          clamped_q;

  logic accept;
  assign accept = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);

  // scaling multiplier, one axis a cycle
  logic [CW-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  always_comb begin
    case (step[1:0])
      qti_pkg::AXIS_ANGLE:    begin mul_a = ca;     mul_b = inv_angle;    end
      qti_pkg::AXIS_DISTANCE: begin mul_a = cd;     mul_b = inv_distance; end
      qti_pkg::AXIS_RC:       begin mul_a = rc_mag; mul_b = inv_rc;       end
      default:                begin mul_a = cz;     mul_b = inv_drift;    end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // split of the previous axis' position
  logic [1:0]    axis;
  logic [IW-1:0] last;
  logic          rc_low;
  logic [PW-1:0] pq;
  logic [CW-1:0] q_idx;
  logic          q_over;
  logic [IW-1:0] q_lo, q_hi;
  logic [FW-1:0] q_frac;
  logic [CW:0]   r_idx;
  logic          r_ok;
  logic [IW-1:0] r_sel;

  always_comb begin
    axis   = 2'(step - 3'd1);
    last   = qti_pkg::axis_last(axis);
    rc_low = (axis == qti_pkg::AXIS_RC) && rc_below;
    pq     = rc_low ? '0 : pos;
    q_idx  = pq[PW-1:PW-CW];
    q_over = (q_idx > CW'(last)) || ((q_idx == CW'(last)) && (pq[PW-CW-1:0] != '0));
    q_lo   = q_over ? last : q_idx[IW-1:0];
    q_hi   = (q_lo < last) ? q_lo + 1'b1 : last;
    q_frac = q_over ? '0 : pq[PW-CW-1:PW-CW-FW];
    // round half up to nearest grid point
    r_idx  = {1'b0, pos[PW-1:PW-CW]} + (CW+1)'(pos[PW-CW-1]);
    // below offset: lands on point 0 only within half a step
    r_ok   = rc_low ? (pos[PW-1:PW-CW-1] == '0) : (r_idx <= (CW+1)'(last));
    r_sel  = rc_low ? '0 : r_idx[IW-1:0];
  end

  // corner selection
  logic [3:0]    cb;
  logic [WW-1:0] wa, wd, wr, wz;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  logic [VW-1:0] wdata;

  always_comb begin
    cb    = corner[3:0];
    wa    = cb[3] ? WW'(frac[0]) : ONE_W - WW'(frac[0]);
    wd    = cb[2] ? WW'(frac[1]) : ONE_W - WW'(frac[1]);
    wr    = cb[1] ? WW'(frac[2]) : ONE_W - WW'(frac[2]);
    wz    = cb[0] ? WW'(frac[3]) : ONE_W - WW'(frac[3]);
    raddr = grid_addr(cb[3] ? hi[0] : lo[0], cb[2] ? hi[1] : lo[1],
                      cb[1] ? hi[2] : lo[2], cb[0] ? hi[3] : lo[3]);
    we    = (state == ST_CLEAR) || ((state == ST_WRITE) && load_ok);
    waddr = (state == ST_CLEAR) ? clr_addr : grid_addr(ridx[0], ridx[1], ridx[2], ridx[3]);
    wdata = (state == ST_CLEAR) ? '0 : value;
  end

  logic [VW-1:0] table_mem [qti_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    rdata <= table_mem[raddr];
  end

  // weighting datapath
  logic [2*PAIR_W-1:0] w_full;
  assign w_full = (2*PAIR_W)'(w01) * (2*PAIR_W)'(w23);

  always_ff @(posedge clk) begin
    w01  <= PAIR_W'(wa) * PAIR_W'(wd);
    w23  <= PAIR_W'(wr) * PAIR_W'(wz);
    wc   <= w_full[2*FW+CORNER_W-1:2*FW];
    val  <= rdata;
    prod <= PROD_W'(val) * PROD_W'(wc);
  end

  // rounding and saturation of the sum
  logic [ACC_W-1:0]   acc_rnd;
  logic [ACC_W-2*FW-1:0] acc_q;
  logic [VW-1:0]      ratio_next;

  always_comb begin
    acc_rnd    = acc + ACC_W'(1 << (2*FW - 1));
    acc_q      = acc_rnd[ACC_W-1:2*FW];
    ratio_next = (acc_q > (ACC_W-2*FW)'({VW{1'b1}})) ? {VW{1'b1}} : acc_q[VW-1:0];
  end

  logic out_free;
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      step      <= '0;
      corner    <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
      if (result.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(qti_pkg::TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            step  <= '0;
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          step <= step + 3'd1;
          if (step == 3'd4) begin
            corner <= '0;
            state  <= (req == qti_pkg::REQ_QUERY) ? ST_BLEND : ST_WRITE;
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_BLEND: begin
          if (!corner[4]) begin
            corner <= corner + 5'd1;
            v1     <= 1'b1;
          end else begin
            v1 <= 1'b0;
            if (!v1 && !v2 && !v3) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // out_free here means either empty or being taken this cycle
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= item.req_type;
      ca       <= item.angle_coord;
      cd       <= item.distance_coord;
      cz       <= item.drift_coord;
      value    <= item.entry_value;
      rc_below <= item.rc_coord < rc_offset;
      rc_mag   <= (item.rc_coord < rc_offset) ? rc_offset - item.rc_coord
                                              : item.rc_coord - rc_offset;
      clamp    <= item.rc_coord < rc_offset;
      load_ok  <= 1'b1;
    end
    if (state == ST_SCALE) begin
      pos <= mul_p;
      if (step != 3'd0) begin
        lo[axis]   <= q_lo;
        hi[axis]   <= q_hi;
        frac[axis] <= q_frac;
        ridx[axis] <= r_sel;
        if (q_over) begin
          clamp <= 1'b1;
        end
        if (!r_ok) begin
          load_ok <= 1'b0;
        end
      end
      if (step == 3'd4) begin
        acc <= '0;
      end
    end
    if (state == ST_BLEND && v3) begin
      acc <= acc + prod;
    end
    if (state == ST_DONE && out_free) begin
      ratio_q   <= ratio_next;
      clamped_q <= clamp;
    end
  end

  assign result.valid   = out_valid;
  assign result.ratio   = ratio_q;
  assign result.clamped = clamped_q;

endmodule

FILE: sim/quadrilinear_table_interpolator_top_test.sv
`timescale 1ns / 100ps

module quadrilinear_table_interpolator_top_test;

  typedef struct {
    logic                        req_type;
    logic [qti_pkg::COORD_W-1:0] angle;
    logic [qti_pkg::COORD_W-1:0] distance;
    logic [qti_pkg::COORD_W-1:0] rc;
    logic [qti_pkg::COORD_W-1:0] drift;
    logic [qti_pkg::VALUE_W-1:0] value;
  } table_request_t;

  typedef struct {
    logic [qti_pkg::VALUE_W-1:0] ratio;
    logic                        clamped;
  } ratio_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [qti_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qti_pkg::CFG_DATA_W-1:0] cfg_data;

  qti_item_if   request_bus ();
  qti_result_if ratio_bus ();

  quadrilinear_table_interpolator_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (request_bus),
    .result    (ratio_bus)
  );

  // mirror of the block's state
  logic [qti_pkg::VALUE_W-1:0] weight_mirror [qti_pkg::TABLE_DEPTH];
  logic [qti_pkg::STEP_W-1:0]  axis_step [4];
  logic [qti_pkg::COORD_W-1:0] rc_origin;

  table_request_t queued_requests [$];
  ratio_result_t  expected_ratios [$];

  int error_count;
  int loads_sent;
  int queries_sent;
  int ratios_checked;
  int clamps_seen;
  int tx_gap;
  int rx_stall;
  bit tx_calm;
  bit rx_calm;
  bit drain_hold;
  table_request_t taken;
  ratio_result_t  wanted;

  always #1 clk = ~clk;

  function automatic int axis_points(input int k);
    int npts [4];
    npts = '{qti_pkg::ANGLE_POINTS, qti_pkg::DISTANCE_POINTS, qti_pkg::RC_POINTS,
             qti_pkg::DRIFT_POINTS};
    return npts[k];
  endfunction

  function automatic int cell_addr(input int a, input int d, input int r, input int z);
    return ((a * qti_pkg::DISTANCE_POINTS + d) * qti_pkg::RC_POINTS + r)
           * qti_pkg::DRIFT_POINTS + z;
  endfunction

  // Q24.24 grid positions; RC below the origin sits at zero
  function automatic void axis_positions(input table_request_t rq, output logic [47:0] pos [4]);
    pos[qti_pkg::AXIS_ANGLE]    = 48'(rq.angle) * 48'(axis_step[qti_pkg::AXIS_ANGLE]);
    pos[qti_pkg::AXIS_DISTANCE] = 48'(rq.distance) * 48'(axis_step[qti_pkg::AXIS_DISTANCE]);
    pos[qti_pkg::AXIS_DRIFT]    = 48'(rq.drift) * 48'(axis_step[qti_pkg::AXIS_DRIFT]);
    if (rq.rc < rc_origin) begin
      pos[qti_pkg::AXIS_RC] = '0;
    end else begin
      pos[qti_pkg::AXIS_RC] = 48'(rq.rc - rc_origin) * 48'(axis_step[qti_pkg::AXIS_RC]);
    end
  endfunction

  function automatic void apply_load(input table_request_t rq);
    logic [47:0] pos [4];
    logic [47:0] under;
    logic [48:0] nearest;
    int          idx [4];
    bit          on_grid;
    axis_positions(rq, pos);
    on_grid = 1'b1;
    for (int k = 0; k < 4; k++) begin
      idx[k] = 0;
      if (k == qti_pkg::AXIS_RC && rq.rc < rc_origin) begin
        // within half a step below the origin still lands on point 0
        under = 48'(rc_origin - rq.rc) * 48'(axis_step[qti_pkg::AXIS_RC]);
        if (under >= 48'h800000) on_grid = 1'b0;
      end else begin
        nearest = (49'(pos[k]) + 49'h800000) >> 24;
        if (nearest > 49'(axis_points(k) - 1)) on_grid = 1'b0;
        else idx[k] = int'(nearest);
      end
    end
    if (on_grid) weight_mirror[cell_addr(idx[0], idx[1], idx[2], idx[3])] = rq.value;
  endfunction

  function automatic ratio_result_t interpolate_ratio(input table_request_t rq);
    logic [47:0]  pos [4];
    logic [23:0]  grid_idx;
    logic [63:0]  frac [4];
    logic [63:0]  wt;
    logic [63:0]  acc;
    int           lo [4];
    int           hi [4];
    int           ix [4];
    int           last;
    bit           up;
    ratio_result_t res;
    axis_positions(rq, pos);
    res.clamped = rq.rc < rc_origin;
    for (int k = 0; k < 4; k++) begin
      last = axis_points(k) - 1;
      grid_idx = pos[k][47:24];
      frac[k] = 64'(pos[k][23:10]);
      if (grid_idx > 24'(last) || (grid_idx == 24'(last) && pos[k][23:0] != 0)) begin
        grid_idx = 24'(last);
        frac[k] = '0;
        res.clamped = 1'b1;
      end
      lo[k] = int'(grid_idx);
      hi[k] = (lo[k] < last) ? lo[k] + 1 : last;
    end
    acc = '0;
    for (int c = 0; c < 16; c++) begin
      wt = 64'd1;
      for (int k = 0; k < 4; k++) begin
        up = ((c >> (3 - k)) & 1) != 0;
        ix[k] = up ? hi[k] : lo[k];
        wt = wt * (up ? frac[k] : 64'd16384 - frac[k]);
      end
      acc += 64'(weight_mirror[cell_addr(ix[0], ix[1], ix[2], ix[3])]) * (wt >> 28);
    end
    acc = (acc + 64'd134217728) >> 28;
    res.ratio = (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
    return res;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = 25'(a) + 25'(b);
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  // coordinate nearest to grid point idx for a given reciprocal step
  function automatic logic [23:0] grid_coord(input int idx, input logic [23:0] step);
    logic [63:0] c;
    if (step == 0) return 24'($urandom);
    c = ((64'(idx) << 24) + 64'(step >> 1)) / 64'(step);
    return (c > 64'hFFFFFF) ? 24'hFFFFFF : c[23:0];
  endfunction

  task automatic push_request(input logic kind, input logic [23:0] a, input logic [23:0] d,
                              input logic [23:0] r, input logic [23:0] z,
                              input logic [15:0] v);
    table_request_t rq;
    rq.req_type = kind;
    rq.angle    = a;
    rq.distance = d;
    rq.rc       = r;
    rq.drift    = z;
    rq.value    = v;
    queued_requests = {queued_requests, rq};
  endtask

  // fill the 16 corners of one grid box, then query inside it (now and then past it)
  task automatic push_cell_sequence(inout int pushed);
    logic [23:0] c_lo [4];
    logic [23:0] c_hi [4];
    logic [23:0] pick [4];
    int          base;
    int          n_query;
    for (int k = 0; k < 4; k++) begin
      base = $urandom_range(0, axis_points(k) - 2);
      c_lo[k] = grid_coord(base, axis_step[k]);
      c_hi[k] = grid_coord(base + 1, axis_step[k]);
    end
    c_lo[qti_pkg::AXIS_RC] = sat_add(c_lo[qti_pkg::AXIS_RC], rc_origin);
    c_hi[qti_pkg::AXIS_RC] = sat_add(c_hi[qti_pkg::AXIS_RC], rc_origin);
    for (int c = 0; c < 16; c++) begin
      push_request(qti_pkg::REQ_LOAD, c[3] ? c_hi[0] : c_lo[0], c[2] ? c_hi[1] : c_lo[1],
                   c[1] ? c_hi[2] : c_lo[2], c[0] ? c_hi[3] : c_lo[3], 16'($urandom));
    end
    n_query = $urandom_range(1, 4);
    for (int q = 0; q < n_query; q++) begin
      for (int k = 0; k < 4; k++) begin
        pick[k] = 24'($urandom_range(c_lo[k], c_hi[k]));
        if ($urandom_range(0, 23) == 0) pick[k] = sat_add(c_hi[k], 24'($urandom_range(1, 2048)));
      end
      push_request(qti_pkg::REQ_QUERY, pick[0], pick[1], pick[2], pick[3], 16'($urandom));
    end
    pushed += 16 + n_query;
  endtask

  task automatic push_random(input int count);
    int pushed;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 7) begin
        push_cell_sequence(pushed);
      end else begin
        push_request(1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 16'($urandom));
        pushed++;
      end
    end
  endtask

  task automatic write_register(input logic [qti_pkg::CFG_IDX_W-1:0] idx,
                                input logic [qti_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      qti_pkg::REG_INV_STEP_ANGLE:    axis_step[qti_pkg::AXIS_ANGLE] = data;
      qti_pkg::REG_INV_STEP_DISTANCE: axis_step[qti_pkg::AXIS_DISTANCE] = data;
      qti_pkg::REG_INV_STEP_RC:       axis_step[qti_pkg::AXIS_RC] = data;
      qti_pkg::REG_INV_STEP_DRIFT:    axis_step[qti_pkg::AXIS_DRIFT] = data;
      qti_pkg::REG_RC_OFFSET:         rc_origin = data;
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [23:0] sa, input logic [23:0] sd, input logic [23:0] sr,
                          input logic [23:0] sz, input logic [23:0] origin);
    write_register(qti_pkg::REG_INV_STEP_ANGLE, sa);
    write_register(qti_pkg::REG_INV_STEP_DISTANCE, sd);
    write_register(qti_pkg::REG_INV_STEP_RC, sr);
    write_register(qti_pkg::REG_INV_STEP_DRIFT, sz);
    write_register(qti_pkg::REG_RC_OFFSET, origin);
  endtask

  // sampled on the falling edge, clear of the driver's updates
  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (queued_requests.size() != 0 || request_bus.valid || expected_ratios.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      request_bus.valid <= 1'b0;
    end else begin
      if (request_bus.valid && request_bus.ready) begin
        taken.req_type = request_bus.req_type;
        taken.angle    = request_bus.angle_coord;
        taken.distance = request_bus.distance_coord;
        taken.rc       = request_bus.rc_coord;
        taken.drift    = request_bus.drift_coord;
        taken.value    = request_bus.entry_value;
        if (taken.req_type == qti_pkg::REQ_QUERY) begin
          expected_ratios = {expected_ratios, interpolate_ratio(taken)};
          queries_sent++;
        end else begin
          apply_load(taken);
          loads_sent++;
        end
        if ((loads_sent + queries_sent) % 64 == 63) drain_hold = 1'b1;
      end
      if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
      if (!request_bus.valid || request_bus.ready) begin
        if (drain_hold && expected_ratios.size() == 0) drain_hold = 1'b0;
        if (drain_hold || tx_gap > 0 || queued_requests.size() == 0) begin
          if (!drain_hold && tx_gap > 0) tx_gap--;
          request_bus.valid <= 1'b0;
        end else begin
          taken = queued_requests.pop_front();
          request_bus.req_type       <= taken.req_type;
          request_bus.angle_coord    <= taken.angle;
          request_bus.distance_coord <= taken.distance;
          request_bus.rc_coord       <= taken.rc;
          request_bus.drift_coord    <= taken.drift;
          request_bus.entry_value    <= taken.value;
          request_bus.valid          <= 1'b1;
          tx_gap = pick_gap(tx_calm);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      ratio_bus.ready <= 1'b0;
    end else begin
      if (ratio_bus.valid && ratio_bus.ready) begin
        if (expected_ratios.size() == 0) begin
          report_mismatch($sformatf("unexpected word ratio=%h clamped=%b",
                                    ratio_bus.ratio, ratio_bus.clamped));
        end else begin
          wanted = expected_ratios.pop_front();
          ratios_checked++;
          if (wanted.clamped) clamps_seen++;
          if (ratio_bus.ratio !== wanted.ratio)
            report_mismatch($sformatf("ratio %h, expected %h", ratio_bus.ratio, wanted.ratio));
          if (ratio_bus.clamped !== wanted.clamped)
            report_mismatch($sformatf("clamped %b, expected %b (ratio %h)",
                                      ratio_bus.clamped, wanted.clamped, wanted.ratio));
        end
      end
      if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      if (rx_stall > 0) begin
        rx_stall--;
        ratio_bus.ready <= 1'b0;
      end else begin
        ratio_bus.ready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    request_bus.valid = 1'b0;
    request_bus.req_type = qti_pkg::REQ_LOAD;
    request_bus.angle_coord = '0;
    request_bus.distance_coord = '0;
    request_bus.rc_coord = '0;
    request_bus.drift_coord = '0;
    request_bus.entry_value = '0;
    ratio_bus.ready = 1'b0;
    foreach (weight_mirror[i]) weight_mirror[i] = '0;
    foreach (axis_step[k]) axis_step[k] = qti_pkg::INV_STEP_RESET;
    rc_origin = qti_pkg::RC_OFFSET_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset grid: unit steps, RC origin at 50.0
    push_request(qti_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
    push_request(qti_pkg::REQ_LOAD, 15 * 256, 15 * 256, 12800 + 7 * 256, 7 * 256, 16'hFFFF);
    push_request(qti_pkg::REQ_QUERY, 15 * 256, 15 * 256, 12800 + 7 * 256, 7 * 256, 0);
    push_request(qti_pkg::REQ_QUERY, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    push_request(qti_pkg::REQ_LOAD, 0, 0, 12800, 0, 16'h1234);
    push_request(qti_pkg::REQ_LOAD, 128, 0, 12800, 0, 16'h2000);      // half step rounds up
    push_request(qti_pkg::REQ_LOAD, 0, 0, 12800 - 100, 256, 16'h4000); // just under origin
    push_request(qti_pkg::REQ_LOAD, 0, 0, 12800 - 200, 0, 16'h7777);   // too far under
    push_request(qti_pkg::REQ_LOAD, 16 * 256, 0, 12800, 0, 16'h5555);  // off the grid
    push_request(qti_pkg::REQ_LOAD, 0, 15 * 256 + 127, 12800, 0, 16'hAAAA);
    push_request(qti_pkg::REQ_QUERY, 64, 0, 12800, 0, 0);
    push_request(qti_pkg::REQ_QUERY, 128, 128, 12800 + 128, 128, 0);
    push_request(qti_pkg::REQ_QUERY, 255, 15 * 256, 12800, 255, 0);  // upper corner on last
    push_request(qti_pkg::REQ_QUERY, 0, 0, 12800 - 1, 0, 0);
    push_request(qti_pkg::REQ_QUERY, 15 * 256 + 1, 0, 12800, 0, 0);   // just past last point
    push_request(qti_pkg::REQ_QUERY, 0, 0, 12800 + 7 * 256, 7 * 256 + 255, 0);
    push_request(qti_pkg::REQ_LOAD, 0, 0, 12800, 0, 16'h0000);
    push_request(qti_pkg::REQ_QUERY, 64, 0, 12800, 0, 0);
    push_request(qti_pkg::REQ_LOAD, 256, 256, 12800 + 256, 256, 16'h5555);
    push_request(qti_pkg::REQ_QUERY, 256 + 200, 256 + 17, 12800 + 256 + 99, 256 + 3, 0);
    push_request(qti_pkg::REQ_QUERY, 128, 128, 12800 + 128, 128, 16'hFFFF);
    push_random(250);
    wait_idle(40);

    // fractional steps, RC origin at zero
    set_grid(24'h00C000, 24'h018000, 24'h020000, 24'h008000, 24'h000000);
    push_random(200);
    wait_idle(40);

    // extremes: zero step, largest step, tiny step, largest origin
    set_grid(24'h000000, 24'hFFFFFF, 24'h000001, 24'h010000, 24'hFFFFFF);
    push_request(qti_pkg::REQ_LOAD, 24'hFFFFFF, 0, 24'hFFFFFF, 0, 16'h0F0F);
    push_request(qti_pkg::REQ_QUERY, 24'h123456, 0, 24'hFFFFFF, 0, 0);
    push_request(qti_pkg::REQ_QUERY, 0, 1, 24'hFFFFFF, 0, 0);
    push_request(qti_pkg::REQ_QUERY, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
    push_random(80);
    wait_idle(40);

    set_grid(24'($urandom_range(16'h4000, 20'h40000)), 24'($urandom_range(16'h4000, 20'h40000)),
             24'($urandom_range(16'h4000, 20'h40000)), 24'($urandom_range(16'h4000, 20'h40000)),
             24'($urandom_range(0, 16'h8000)));
    push_random(250);
    wait_idle(60);

    $display("%0d loads and %0d queries over four grid settings (zero and full-scale steps)",
             loads_sent, queries_sent);
    $display("%0d ratios checked, %0d of them clamped at a grid edge", ratios_checked, clamps_seen);
    if (error_count == 0) begin
      $display("quadrilinear_table_interpolator_top_test: clean");
    end else begin
      $display("quadrilinear_table_interpolator_top_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words queued and %0d ratios outstanding",
             queued_requests.size(), expected_ratios.size());
    $display("quadrilinear_table_interpolator_top_test: errors");
    $finish;
  end

endmodule
